@@ hw/rtl/lux_pkg.sv @@
package lux_pkg;

    // field widths
    localparam int CH_W   = 16;
    localparam int LUX_W  = 28;
    localparam int ST_W   = 2;
    localparam int IDX_W  = 3;
    localparam int SEG_W  = 3;
    localparam int COEF_W = 29;
    localparam int PROD_W = COEF_W + CH_W;
    localparam int N_IDX  = 6;
    localparam int N_SEG  = 7;
    localparam int CMP_W  = 24;

    localparam logic [IDX_W-1:0] TOP_IDX = 3'd5;

    // range status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_OVER  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDER = 2'd2;

    // overflow limits per integration time
    localparam logic [CH_W-1:0] LIM_SHORT = 16'd4900;
    localparam logic [CH_W-1:0] LIM_MID   = 16'd37000;
    localparam logic [CH_W-1:0] LIM_LONG  = 16'd65000;

    // segment upper bounds on ch1/ch0, inclusive
    localparam logic [6:0] SEG_NUM [N_SEG] = '{7'd1, 7'd1, 7'd3, 7'd1, 7'd61, 7'd4, 7'd13};
    localparam logic [6:0] SEG_DEN [N_SEG] = '{7'd8, 7'd4, 7'd8, 7'd2, 7'd100, 7'd5, 7'd10};

    // scale per index folded with 2^24 and the 1e-5 coefficient unit
    localparam logic [63:0] Q24 = 64'd16777216;
    localparam logic [63:0] M0 = 64'd5152 * Q24;
    localparam logic [63:0] M1 = 64'd5152 * Q24;
    localparam logic [63:0] M2 = 64'd322 * Q24;
    localparam logic [63:0] M3 = 64'd16 * Q24;
    localparam logic [63:0] M4 = 64'd322 * Q24;
    localparam logic [63:0] M5 = 64'd1 * Q24;
    localparam logic [63:0] D0 = 64'd100000 * 64'd11;
    localparam logic [63:0] D1 = 64'd100000 * 64'd81;
    localparam logic [63:0] D2 = 64'd100000 * 64'd11;
    localparam logic [63:0] D3 = 64'd100000 * 64'd1;
    localparam logic [63:0] D4 = 64'd100000 * 64'd81;
    localparam logic [63:0] D5 = 64'd100000 * 64'd1;
    localparam logic [63:0] H0 = D0 / 2;
    localparam logic [63:0] H1 = D1 / 2;
    localparam logic [63:0] H2 = D2 / 2;
    localparam logic [63:0] H3 = D3 / 2;
    localparam logic [63:0] H4 = D4 / 2;
    localparam logic [63:0] H5 = D5 / 2;

    // broadband coefficients, rounded half up
    localparam logic [COEF_W-1:0] COEF_A [N_IDX][N_SEG] = '{
        '{29'((64'd3040 * M0 + H0) / D0), 29'((64'd3250 * M0 + H0) / D0),
          29'((64'd3510 * M0 + H0) / D0), 29'((64'd3750 * M0 + H0) / D0),
          29'((64'd2240 * M0 + H0) / D0), 29'((64'd1280 * M0 + H0) / D0),
          29'((64'd146 * M0 + H0) / D0)},
        '{29'((64'd3040 * M1 + H1) / D1), 29'((64'd3250 * M1 + H1) / D1),
          29'((64'd3510 * M1 + H1) / D1), 29'((64'd3750 * M1 + H1) / D1),
          29'((64'd2240 * M1 + H1) / D1), 29'((64'd1280 * M1 + H1) / D1),
          29'((64'd146 * M1 + H1) / D1)},
        '{29'((64'd3040 * M2 + H2) / D2), 29'((64'd3250 * M2 + H2) / D2),
          29'((64'd3510 * M2 + H2) / D2), 29'((64'd3750 * M2 + H2) / D2),
          29'((64'd2240 * M2 + H2) / D2), 29'((64'd1280 * M2 + H2) / D2),
          29'((64'd146 * M2 + H2) / D2)},
        '{29'((64'd3040 * M3 + H3) / D3), 29'((64'd3250 * M3 + H3) / D3),
          29'((64'd3510 * M3 + H3) / D3), 29'((64'd3750 * M3 + H3) / D3),
          29'((64'd2240 * M3 + H3) / D3), 29'((64'd1280 * M3 + H3) / D3),
          29'((64'd146 * M3 + H3) / D3)},
        '{29'((64'd3040 * M4 + H4) / D4), 29'((64'd3250 * M4 + H4) / D4),
          29'((64'd3510 * M4 + H4) / D4), 29'((64'd3750 * M4 + H4) / D4),
          29'((64'd2240 * M4 + H4) / D4), 29'((64'd1280 * M4 + H4) / D4),
          29'((64'd146 * M4 + H4) / D4)},
        '{29'((64'd3040 * M5 + H5) / D5), 29'((64'd3250 * M5 + H5) / D5),
          29'((64'd3510 * M5 + H5) / D5), 29'((64'd3750 * M5 + H5) / D5),
          29'((64'd2240 * M5 + H5) / D5), 29'((64'd1280 * M5 + H5) / D5),
          29'((64'd146 * M5 + H5) / D5)}
    };

    // infrared coefficients, rounded half up
    localparam logic [COEF_W-1:0] COEF_B [N_IDX][N_SEG] = '{
        '{29'((64'd2720 * M0 + H0) / D0), 29'((64'd4400 * M0 + H0) / D0),
          29'((64'd5440 * M0 + H0) / D0), 29'((64'd6240 * M0 + H0) / D0),
          29'((64'd3100 * M0 + H0) / D0), 29'((64'd1530 * M0 + H0) / D0),
          29'((64'd112 * M0 + H0) / D0)},
        '{29'((64'd2720 * M1 + H1) / D1), 29'((64'd4400 * M1 + H1) / D1),
          29'((64'd5440 * M1 + H1) / D1), 29'((64'd6240 * M1 + H1) / D1),
          29'((64'd3100 * M1 + H1) / D1), 29'((64'd1530 * M1 + H1) / D1),
          29'((64'd112 * M1 + H1) / D1)},
        '{29'((64'd2720 * M2 + H2) / D2), 29'((64'd4400 * M2 + H2) / D2),
          29'((64'd5440 * M2 + H2) / D2), 29'((64'd6240 * M2 + H2) / D2),
          29'((64'd3100 * M2 + H2) / D2), 29'((64'd1530 * M2 + H2) / D2),
          29'((64'd112 * M2 + H2) / D2)},
        '{29'((64'd2720 * M3 + H3) / D3), 29'((64'd4400 * M3 + H3) / D3),
          29'((64'd5440 * M3 + H3) / D3), 29'((64'd6240 * M3 + H3) / D3),
          29'((64'd3100 * M3 + H3) / D3), 29'((64'd1530 * M3 + H3) / D3),
          29'((64'd112 * M3 + H3) / D3)},
        '{29'((64'd2720 * M4 + H4) / D4), 29'((64'd4400 * M4 + H4) / D4),
          29'((64'd5440 * M4 + H4) / D4), 29'((64'd6240 * M4 + H4) / D4),
          29'((64'd3100 * M4 + H4) / D4), 29'((64'd1530 * M4 + H4) / D4),
          29'((64'd112 * M4 + H4) / D4)},
        '{29'((64'd2720 * M5 + H5) / D5), 29'((64'd4400 * M5 + H5) / D5),
          29'((64'd5440 * M5 + H5) / D5), 29'((64'd6240 * M5 + H5) / D5),
          29'((64'd3100 * M5 + H5) / D5), 29'((64'd1530 * M5 + H5) / D5),
          29'((64'd112 * M5 + H5) / D5)}
    };

    // classify stage to coefficient stage
    typedef struct packed {
        logic [CH_W-1:0]  ch0;
        logic [CH_W-1:0]  ch1;
        logic [IDX_W-1:0] idx;
        logic [SEG_W-1:0] seg;
        logic             zero;
        logic [ST_W-1:0]  status;
    } cls_t;

    // coefficient stage to product stage
    typedef struct packed {
        logic [CH_W-1:0]   ch0;
        logic [CH_W-1:0]   ch1;
        logic [COEF_W-1:0] a;
        logic [COEF_W-1:0] b;
        logic              zero;
        logic [ST_W-1:0]   status;
    } coef_t;

    // product stage to output stage
    typedef struct packed {
        logic [PROD_W-1:0] pa;
        logic [PROD_W-1:0] pb;
        logic              zero;
        logic [ST_W-1:0]   status;
    } prod_t;

    function automatic logic [CH_W-1:0] overflow_limit(input logic [IDX_W-1:0] idx);
        logic [CH_W-1:0] lim;
        case (idx) inside
            3'd0, 3'd2: lim = LIM_SHORT;
            3'd1, 3'd4: lim = LIM_MID;
            default:    lim = LIM_LONG;
        endcase
        return lim;
    endfunction

endpackage

@@ hw/rtl/lux_in_if.sv @@
interface lux_in_if;
    logic                      valid;
    logic                      ready;
    logic [lux_pkg::CH_W-1:0]  channel0_count;
    logic [lux_pkg::CH_W-1:0]  channel1_count;

    modport source (output valid, output channel0_count, output channel1_count, input ready);
    modport sink   (input valid, input channel0_count, input channel1_count, output ready);
endinterface

@@ hw/rtl/lux_out_if.sv @@
interface lux_out_if;
    logic                      valid;
    logic                      ready;
    logic [lux_pkg::LUX_W-1:0] lux_value;
    logic [lux_pkg::ST_W-1:0]  range_status;

    modport source (output valid, output lux_value, output range_status, input ready);
    modport sink   (input valid, input lux_value, input range_status, output ready);
endinterface

@@ hw/rtl/lux_cls.sv @@
// stage 1: range status and ratio segment
module lux_cls (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  logic [lux_pkg::CH_W-1:0]   ch0,
    input  logic [lux_pkg::CH_W-1:0]   ch1,
    input  logic [lux_pkg::IDX_W-1:0]  idx,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output lux_pkg::cls_t              dn_data
);

    logic                          valid_reg;
    logic                          valid_next;
    lux_pkg::cls_t                 data_reg;
    lux_pkg::cls_t                 data_next;
    logic [lux_pkg::CH_W-1:0]      limit;
    logic [lux_pkg::N_SEG-1:0]     hit;
    logic [lux_pkg::SEG_W-1:0]     seg;
    logic                          found;
    logic [lux_pkg::ST_W-1:0]      status;

    assign limit = lux_pkg::overflow_limit(idx);

    // channel 0 checks first, then channel 1
    always_comb
    begin
        if (idx != 3'd0 && ch0 >= limit)
            status = lux_pkg::ST_OVER;
        else if (idx != lux_pkg::TOP_IDX && ch0 == '0)
            status = lux_pkg::ST_UNDER;
        else if (idx != 3'd0 && ch1 >= limit)
            status = lux_pkg::ST_OVER;
        else if (idx != lux_pkg::TOP_IDX && ch1 == '0)
            status = lux_pkg::ST_UNDER;
        else
            status = lux_pkg::ST_OK;
    end

    // exact cross-multiplied ratio compares, first hit wins
    always_comb
    begin
        seg   = '0;
        found = 1'b0;
        for (int s = 0; s < lux_pkg::N_SEG; s++)
        begin
            hit[s] = (lux_pkg::CMP_W'(ch1) * lux_pkg::CMP_W'(lux_pkg::SEG_DEN[s]))
                  <= (lux_pkg::CMP_W'(ch0) * lux_pkg::CMP_W'(lux_pkg::SEG_NUM[s]));
        end
        for (int s = lux_pkg::N_SEG - 1; s >= 0; s--)
        begin
            if (hit[s])
            begin
                seg   = lux_pkg::SEG_W'(s);
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        data_next.ch0    = ch0;
        data_next.ch1    = ch1;
        data_next.idx    = idx;
        data_next.seg    = found ? seg : '0;
        data_next.zero   = (status != lux_pkg::ST_OK) || (ch0 == '0) || !found;
        data_next.status = status;
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

@@ hw/rtl/lux_coef.sv @@
// stage 2: folded coefficient lookup
module lux_coef (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  lux_pkg::cls_t   up_data,
    output logic            dn_valid,
    input  logic            dn_ready,
    output lux_pkg::coef_t  dn_data
);

    logic            valid_reg;
    logic            valid_next;
    lux_pkg::coef_t  data_reg;
    lux_pkg::coef_t  data_next;

    always_comb
    begin
        data_next.ch0    = up_data.ch0;
        data_next.ch1    = up_data.ch1;
        data_next.a      = lux_pkg::COEF_A[up_data.idx][up_data.seg];
        data_next.b      = lux_pkg::COEF_B[up_data.idx][up_data.seg];
        data_next.zero   = up_data.zero;
        data_next.status = up_data.status;
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

@@ hw/rtl/lux_prod.sv @@
// stage 3: the two coefficient products
module lux_prod (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_ready,
    input  lux_pkg::coef_t  up_data,
    output logic            dn_valid,
    input  logic            dn_ready,
    output lux_pkg::prod_t  dn_data
);

    logic            valid_reg;
    logic            valid_next;
    lux_pkg::prod_t  data_reg;
    lux_pkg::prod_t  data_next;

    always_comb
    begin
        data_next.pa     = lux_pkg::PROD_W'(up_data.a) * lux_pkg::PROD_W'(up_data.ch0);
        data_next.pb     = lux_pkg::PROD_W'(up_data.b) * lux_pkg::PROD_W'(up_data.ch1);
        data_next.zero   = up_data.zero;
        data_next.status = up_data.status;
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

@@ hw/rtl/lux_fin.sv @@
// stage 4: difference, rounding, saturation, output register
module lux_fin (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  lux_pkg::prod_t             up_data,
    output logic                       dn_valid,
    input  logic                       dn_ready,
    output logic [lux_pkg::LUX_W-1:0]  lux,
    output logic [lux_pkg::ST_W-1:0]   status
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [lux_pkg::LUX_W-1:0]     lux_reg;
    logic [lux_pkg::LUX_W-1:0]     lux_next;
    logic [lux_pkg::ST_W-1:0]      status_reg;
    logic [lux_pkg::PROD_W-1:0]    diff;
    logic [lux_pkg::PROD_W:0]      rnd;
    logic [lux_pkg::PROD_W-16:0]   q;
    logic                          pos;

    always_comb
    begin
        pos  = up_data.pa > up_data.pb;
        diff = up_data.pa - up_data.pb;
        rnd  = {1'b0, diff} + (lux_pkg::PROD_W + 1)'(1 << 15);
        q    = rnd[lux_pkg::PROD_W:16];
        if (up_data.zero || !pos)
            lux_next = '0;
        else if (q[lux_pkg::PROD_W-16:lux_pkg::LUX_W] != '0)
            lux_next = '1;
        else
            lux_next = q[lux_pkg::LUX_W-1:0];
    end

    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            lux_reg    <= lux_next;
            status_reg <= up_data.status;
        end
    end

    assign dn_valid = valid_reg;
    assign lux      = lux_reg;
    assign status   = status_reg;

endmodule

@@ hw/rtl/lux_from_two_channel_counts_unit.sv @@
// lux from two photodiode counts: each accepted beat on sample carries a broadband and an
// infrared count and yields exactly one beat on result with lux in unsigned q20.8
// (saturating) and a range status (ok, too sensitive, too insensitive). the sensitivity
// index is written through wr_en/wr_data and is only to be changed while the unit is
// empty; values six and seven behave as five. the unit is a four-stage pipeline
// (classify, coefficient lookup, multiply, round and saturate), so a beat is taken every
// cycle while result is not stalled, and each beat is registered by every stage in turn;
// the depth is set by the two 29x16 multipliers and the 45-bit subtract after them.
// a stall backs up stage by stage and nothing is dropped or repeated
module lux_from_two_channel_counts_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    lux_in_if.sink                     sample,
    lux_out_if.source                  result,
    input  logic                       wr_en,
    input  logic [lux_pkg::IDX_W-1:0]  wr_data
);

    // sensitivity index register
    logic [lux_pkg::IDX_W-1:0]  sens_reg;
    logic [lux_pkg::IDX_W-1:0]  sens_next;
    logic [lux_pkg::IDX_W-1:0]  idx;

    // stage handshakes and payloads
    logic            cls_valid;
    logic            cls_ready;
    lux_pkg::cls_t   cls_data;
    logic            coef_valid;
    logic            coef_ready;
    lux_pkg::coef_t  coef_data;
    logic            prod_valid;
    logic            prod_ready;
    lux_pkg::prod_t  prod_data;

    assign sens_next = wr_en ? wr_data : sens_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sens_reg <= '0;
        else
            sens_reg <= sens_next;
    end

    // indices above the top one saturate
    assign idx = (sens_reg > lux_pkg::TOP_IDX) ? lux_pkg::TOP_IDX : sens_reg;

    // status checks and segment choice
    lux_cls u_cls (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sample.valid),
        .up_ready (sample.ready),
        .ch0      (sample.channel0_count),
        .ch1      (sample.channel1_count),
        .idx      (idx),
        .dn_valid (cls_valid),
        .dn_ready (cls_ready),
        .dn_data  (cls_data)
    );

    // per index and segment coefficients
    lux_coef u_coef (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (cls_valid),
        .up_ready (cls_ready),
        .up_data  (cls_data),
        .dn_valid (coef_valid),
        .dn_ready (coef_ready),
        .dn_data  (coef_data)
    );

    // broadband and infrared products
    lux_prod u_prod (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (coef_valid),
        .up_ready (coef_ready),
        .up_data  (coef_data),
        .dn_valid (prod_valid),
        .dn_ready (prod_ready),
        .dn_data  (prod_data)
    );

    // difference, rounding and clamp; its register is the output register
    lux_fin u_fin (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (prod_valid),
        .up_ready (prod_ready),
        .up_data  (prod_data),
        .dn_valid (result.valid),
        .dn_ready (result.ready),
        .lux      (result.lux_value),
        .status   (result.range_status)
    );

`ifndef SYNTH
    // any range fault forces lux to zero
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.range_status != lux_pkg::ST_OK |-> result.lux_value == '0)
        else $error("lux not zero on range fault");

    // least sensitive setting can never overflow, most sensitive never under-range
    a_status_idx: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> !(idx == 3'd0 && result.range_status == lux_pkg::ST_OVER)
                      && !(idx == lux_pkg::TOP_IDX && result.range_status == lux_pkg::ST_UNDER))
        else $error("range status impossible for sensitivity index");

    // an empty output register lets the whole pipe advance
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !result.valid |-> sample.ready)
        else $error("input stalled while output register empty");
`endif

endmodule
